// ===== src/piev_pkg.sv =====
// ----------------------------------------------------------------------------
// piev_pkg : shared types and codes for the power iteration eigen block
// Holds the sequencer state type, action, status and register codes, and register reset values.
// ----------------------------------------------------------------------------
package piev_pkg;

  localparam logic [1:0] ACT_LOAD_MATRIX = 2'd0;
  localparam logic [1:0] ACT_LOAD_GUESS  = 2'd1;
  localparam logic [1:0] ACT_START       = 2'd2;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_LIMIT     = 2'd1;
  localparam logic [1:0] ST_ZERO_DIV  = 2'd2;

  localparam logic [1:0] REG_ORDER      = 2'd0;
  localparam logic [1:0] REG_TOLERANCE  = 2'd1;
  localparam logic [1:0] REG_ITER_LIMIT = 2'd2;

  localparam logic [3:0]  ORDER_RST = 4'd10;
  localparam logic [15:0] TOL_RST   = 16'd33;
  localparam logic [15:0] LIMIT_RST = 16'd1000;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_MV_RD,
    S_MV_MUL,
    S_MV_ACC,
    S_MAX,
    S_CHECK,
    S_DV_LOAD,
    S_DV_RUN,
    S_DV_DONE,
    S_EMIT_EV,
    S_EMIT_ERR
  } state_t;

endpackage

// ===== src/piev_ram.sv =====
// ----------------------------------------------------------------------------
// piev_ram : generic single-port-write, single-port-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module piev_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/power_iteration_eigen.sv =====
// ----------------------------------------------------------------------------
// power_iteration_eigen : dominant eigenvalue by power iteration, Q16.16
// Usage: load matrix entries (tuser 0) and guess entries (tuser 1) on the
// input stream, one transfer per cycle, then a start transfer (tuser 2).
// The block then runs x = A*guess and repeated normalize/multiply rounds
// until |m0-m1| <= tolerance or the round count reaches iteration_limit.
// Results leave on the output stream: the eigenvalue (tuser 1), then n
// normalized vector elements, tlast on the final one; a zero divisor gives
// a single eigenvalue item with status 2 and tlast.
// A solve is held in one shared multiplier and one restoring divider: each
// round runs a max search, a division per element and a matrix-vector
// product, and each output element takes one more division. in_tready
// stays low for the whole solve.
// A single output register holds a result while the receiver stalls; the
// sequencer waits for that register to free. Reset restores the registers
// to order 10, tolerance 33, limit 1000; matrix and guess stores are
// undefined until written.
// ----------------------------------------------------------------------------
module power_iteration_eigen #(
  parameter int MAX_ORDER  = 10,
  parameter int WORD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // row[3:0], col[7:4], value[39:8]
  input  logic [1:0]  in_tuser,   // action[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // index[3:0], result_value[35:4], status[37:36], zero
  output logic        out_tuser,  // is_eigenvalue
  output logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int W     = WORD_WIDTH;
  localparam int IW    = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CW    = $clog2(MAX_ORDER + 1);
  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = 2 * W;
  localparam int ACC_W = PW - 16 + $clog2(MAX_ORDER) + 1;
  localparam int SW0   = (ACC_W > W + 18) ? ACC_W : W + 18;
  localparam int SW    = (SW0 > 34) ? SW0 : 34;
  localparam int DVW   = W + 16;
  localparam int DCW   = $clog2(DVW + 1);

  localparam logic signed [SW-1:0] WMAX = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] WMIN = ~WMAX;

  function automatic logic signed [W-1:0] sat_w(input logic signed [SW-1:0] v);
    if (v > WMAX) return WMAX[W-1:0];
    else if (v < WMIN) return WMIN[W-1:0];
    else return v[W-1:0];
  endfunction

  // input fields
  logic [1:0]         in_action;
  logic [3:0]         in_row;
  logic [3:0]         in_col;
  logic signed [31:0] in_value;
  assign in_action = in_tuser;
  assign in_row    = in_tdata[3:0];
  assign in_col    = in_tdata[7:4];
  assign in_value  = in_tdata[39:8];

  // configuration
  logic [3:0]  order_r;
  logic [15:0] tolerance_r;
  logic [15:0] limit_r;
  logic        cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r     <= piev_pkg::ORDER_RST;
      tolerance_r <= piev_pkg::TOL_RST;
      limit_r     <= piev_pkg::LIMIT_RST;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        piev_pkg::REG_ORDER:      order_r     <= pwdata[3:0];
        piev_pkg::REG_TOLERANCE:  tolerance_r <= pwdata[15:0];
        piev_pkg::REG_ITER_LIMIT: limit_r     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      piev_pkg::REG_ORDER:      prdata = {28'd0, order_r};
      piev_pkg::REG_TOLERANCE:  prdata = {16'd0, tolerance_r};
      piev_pkg::REG_ITER_LIMIT: prdata = {16'd0, limit_r};
      default:                  prdata = 32'd0;
    endcase
  end

  // effective order and limit
  logic [CW-1:0] n_eff;
  logic [15:0]   lim_eff;
  always_comb begin
    if (order_r == 4'd0) n_eff = CW'(1);
    else if ({1'b0, order_r} > 5'(MAX_ORDER)) n_eff = CW'(MAX_ORDER);
    else n_eff = CW'(order_r);
  end
  assign lim_eff = (limit_r == 16'd0) ? 16'd1 : limit_r;

  // state and datapath registers
  piev_pkg::state_t state_r, state_nxt;

  logic signed [W-1:0]  guess_r [MAX_ORDER];
  logic signed [W-1:0]  nrm_r   [MAX_ORDER];
  logic signed [W-1:0]  vec_r   [MAX_ORDER];
  logic [CW-1:0]        i_r;
  logic [CW-1:0]        k_r;
  logic [AW:0]          base_r;
  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] acc_r;
  logic signed [W-1:0]  m_r;
  logic signed [W-1:0]  m0_r;
  logic                 first_r;
  logic                 out_mode_r;
  logic [1:0]           status_r;
  logic [15:0]          iter_cnt_r;
  logic [DVW-1:0]       q_r;
  logic [W:0]           rem_r;
  logic [W-1:0]         dm_r;
  logic                 neg_r;
  logic [DCW-1:0]       dcnt_r;

  logic                 out_tvalid_r;
  logic [3:0]           out_index_r;
  logic [31:0]          out_value_r;
  logic [1:0]           out_status_r;
  logic                 out_ev_r;
  logic                 out_last_r;

  // control
  logic in_xfer, ram_we, row_ok, col_ok, slot_free, out_load;
  assign in_xfer   = in_tvalid & in_tready;
  assign row_ok    = ({1'b0, in_row} < 5'(MAX_ORDER));
  assign col_ok    = ({1'b0, in_col} < 5'(MAX_ORDER));
  assign slot_free = ~out_tvalid_r | out_tready;

  always_comb begin
    in_tready = (state_r == piev_pkg::S_IDLE);
    ram_we    = in_xfer && (in_action == piev_pkg::ACT_LOAD_MATRIX) && row_ok && col_ok;
    out_load  = slot_free && ((state_r == piev_pkg::S_EMIT_EV) ||
                              (state_r == piev_pkg::S_EMIT_ERR) ||
                              ((state_r == piev_pkg::S_DV_DONE) && out_mode_r));
  end

  // matrix store
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [W-1:0]  ram_wdata, ram_rdata;
  logic signed [SW-1:0] val_ext;

  assign val_ext   = {{(SW-32){in_value[31]}}, in_value};
  assign ram_wdata = sat_w(val_ext);
  assign ram_waddr = AW'(8'(in_row) * 8'(MAX_ORDER) + 8'(in_col));
  assign ram_raddr = AW'(base_r + (AW+1)'(k_r));

  piev_ram #(.WIDTH(W), .DEPTH(DEPTH)) u_mat (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // arithmetic
  logic signed [PW-17:0] prod_sh;
  logic signed [SW-1:0]  acc_nxt;
  logic                  k_last, i_last;
  logic signed [W:0]     diff;
  logic [W:0]            adiff;
  logic                  conv, hit;
  logic [15:0]           iter_inc;
  logic signed [W-1:0]   dv_num, dv_den;
  logic [W-1:0]          num_mag, den_mag;
  logic [W:0]            dv_t;
  logic                  dv_ge;
  logic [SW-1:0]         q_ext;
  logic signed [W-1:0]   div_res;
  logic signed [SW-1:0]  m_ext, res_ext;

  assign prod_sh  = prod_r[PW-1:16];
  assign acc_nxt  = acc_r + {{(SW-PW+16){prod_sh[PW-17]}}, prod_sh};
  assign k_last   = (k_r == n_eff - CW'(1));
  assign i_last   = (i_r == n_eff - CW'(1));
  assign diff     = {m0_r[W-1], m0_r} - {m_r[W-1], m_r};
  assign adiff    = diff[W] ? (~diff + 1'b1) : diff;
  assign conv     = (adiff <= {{(W+1-16){1'b0}}, tolerance_r});
  assign iter_inc = iter_cnt_r + 16'd1;
  assign hit      = (iter_inc >= lim_eff);
  assign dv_num   = vec_r[i_r[IW-1:0]];
  assign dv_den   = out_mode_r ? m_r : m0_r;
  assign num_mag  = dv_num[W-1] ? (~dv_num + 1'b1) : dv_num;
  assign den_mag  = dv_den[W-1] ? (~dv_den + 1'b1) : dv_den;
  assign dv_t     = {rem_r[W-1:0], q_r[DVW-1]};
  assign dv_ge    = (dv_t >= {1'b0, dm_r});
  assign q_ext    = {{(SW-DVW){1'b0}}, q_r};
  assign div_res  = sat_w(neg_r ? -$signed(q_ext) : $signed(q_ext));
  assign m_ext    = {{(SW-W){m_r[W-1]}}, m_r};
  assign res_ext  = {{(SW-W){div_res[W-1]}}, div_res};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      piev_pkg::S_IDLE:
        if (in_xfer && (in_action == piev_pkg::ACT_START)) state_nxt = piev_pkg::S_START;
      piev_pkg::S_START:  state_nxt = piev_pkg::S_MV_RD;
      piev_pkg::S_MV_RD:  state_nxt = piev_pkg::S_MV_MUL;
      piev_pkg::S_MV_MUL: state_nxt = piev_pkg::S_MV_ACC;
      piev_pkg::S_MV_ACC:
        state_nxt = (k_last && i_last) ? piev_pkg::S_MAX : piev_pkg::S_MV_RD;
      piev_pkg::S_MAX:
        if (i_r >= n_eff) state_nxt = piev_pkg::S_CHECK;
      piev_pkg::S_CHECK: begin
        if (m_r == '0) state_nxt = piev_pkg::S_EMIT_ERR;
        else if (!first_r && (conv || hit)) state_nxt = piev_pkg::S_EMIT_EV;
        else state_nxt = piev_pkg::S_DV_LOAD;
      end
      piev_pkg::S_DV_LOAD: state_nxt = piev_pkg::S_DV_RUN;
      piev_pkg::S_DV_RUN:
        if (dcnt_r == DCW'(DVW - 1)) state_nxt = piev_pkg::S_DV_DONE;
      piev_pkg::S_DV_DONE: begin
        if (out_mode_r) begin
          if (slot_free) state_nxt = i_last ? piev_pkg::S_IDLE : piev_pkg::S_DV_LOAD;
        end else begin
          state_nxt = i_last ? piev_pkg::S_MV_RD : piev_pkg::S_DV_LOAD;
        end
      end
      piev_pkg::S_EMIT_EV:
        if (slot_free) state_nxt = piev_pkg::S_DV_LOAD;
      piev_pkg::S_EMIT_ERR:
        if (slot_free) state_nxt = piev_pkg::S_IDLE;
      default: state_nxt = piev_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= piev_pkg::S_IDLE;
      iter_cnt_r   <= 16'd0;
      out_tvalid_r <= 1'b0;
      first_r      <= 1'b0;
      out_mode_r   <= 1'b0;
      i_r          <= '0;
      k_r          <= '0;
      base_r       <= '0;
      dcnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) out_tvalid_r <= 1'b1;
      else if (out_tready) out_tvalid_r <= 1'b0;

      unique case (state_r)
        piev_pkg::S_IDLE: begin
          if (in_xfer && (in_action == piev_pkg::ACT_LOAD_GUESS) && row_ok)
            guess_r[in_row[IW-1:0]] <= sat_w(val_ext);
        end
        piev_pkg::S_START: begin
          for (int j = 0; j < MAX_ORDER; j++) nrm_r[j] <= guess_r[j];
          iter_cnt_r <= 16'd0;
          first_r    <= 1'b1;
          out_mode_r <= 1'b0;
          i_r        <= '0;
          k_r        <= '0;
          base_r     <= '0;
          acc_r      <= '0;
        end
        piev_pkg::S_MV_RD: ;
        piev_pkg::S_MV_MUL: prod_r <= $signed(ram_rdata) * nrm_r[k_r[IW-1:0]];
        piev_pkg::S_MV_ACC: begin
          if (k_last) begin
            vec_r[i_r[IW-1:0]] <= sat_w(acc_nxt);
            acc_r  <= '0;
            k_r    <= '0;
            base_r <= base_r + (AW+1)'(MAX_ORDER);
            i_r    <= i_last ? '0 : i_r + CW'(1);
          end else begin
            acc_r <= acc_nxt;
            k_r   <= k_r + CW'(1);
          end
        end
        piev_pkg::S_MAX: begin
          if (i_r < n_eff) begin
            if (i_r == '0 || vec_r[i_r[IW-1:0]] > m_r) m_r <= vec_r[i_r[IW-1:0]];
            i_r <= i_r + CW'(1);
          end
        end
        piev_pkg::S_CHECK: begin
          i_r     <= '0;
          first_r <= 1'b0;
          m0_r    <= m_r;
          if (!first_r) begin
            iter_cnt_r <= iter_inc;
            status_r   <= conv ? piev_pkg::ST_CONVERGED : piev_pkg::ST_LIMIT;
          end
        end
        piev_pkg::S_DV_LOAD: begin
          q_r    <= {num_mag, 16'd0};
          rem_r  <= '0;
          dm_r   <= den_mag;
          neg_r  <= dv_num[W-1] ^ dv_den[W-1];
          dcnt_r <= '0;
        end
        piev_pkg::S_DV_RUN: begin
          rem_r  <= dv_ge ? (dv_t - {1'b0, dm_r}) : dv_t;
          q_r    <= {q_r[DVW-2:0], dv_ge};
          dcnt_r <= dcnt_r + DCW'(1);
        end
        piev_pkg::S_DV_DONE: begin
          if (out_mode_r) begin
            if (slot_free) i_r <= i_r + CW'(1);
          end else begin
            nrm_r[i_r[IW-1:0]] <= div_res;
            if (i_last) begin
              i_r    <= '0;
              k_r    <= '0;
              base_r <= '0;
              acc_r  <= '0;
            end else begin
              i_r <= i_r + CW'(1);
            end
          end
        end
        piev_pkg::S_EMIT_EV: begin
          if (slot_free) begin
            out_mode_r <= 1'b1;
            i_r        <= '0;
          end
        end
        piev_pkg::S_EMIT_ERR: ;
        default: ;
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (out_load) begin
      unique case (state_r)
        piev_pkg::S_EMIT_ERR: begin
          out_ev_r     <= 1'b1;
          out_index_r  <= 4'd0;
          out_value_r  <= 32'd0;
          out_status_r <= piev_pkg::ST_ZERO_DIV;
          out_last_r   <= 1'b1;
        end
        piev_pkg::S_EMIT_EV: begin
          out_ev_r     <= 1'b1;
          out_index_r  <= 4'd0;
          out_value_r  <= m_ext[31:0];
          out_status_r <= status_r;
          out_last_r   <= 1'b0;
        end
        default: begin
          out_ev_r     <= 1'b0;
          out_index_r  <= 4'(i_r);
          out_value_r  <= res_ext[31:0];
          out_status_r <= status_r;
          out_last_r   <= i_last;
        end
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {2'b00, out_status_r, out_value_r, out_index_r};
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== src/piev_checker.sv =====
// ----------------------------------------------------------------------------
// piev_checker : port-level checks for power_iteration_eigen
// Watches the input and output stream ports; bound to the top level.
// ----------------------------------------------------------------------------
module piev_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output changed while stalled");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == piev_pkg::ACT_START) |=> !in_tready)
    else $error("input taken during solve");

  a_ev_last_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tlast |-> out_tdata[37:36] == piev_pkg::ST_ZERO_DIV)
    else $error("final eigenvalue item without zero-divisor status");

  a_vec_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[37:36] != piev_pkg::ST_ZERO_DIV)
    else $error("vector item with zero-divisor status");

endmodule

bind power_iteration_eigen piev_checker u_piev_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tuser  (in_tuser),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

// ===== bench/power_iteration_eigen_test.sv =====
// ----------------------------------------------------------------------------
// power_iteration_eigen_test : self-checking bench for power_iteration_eigen
// Loads matrix and guess entries and starts solves on the input stream,
// reprograms order, tolerance and round limit over APB between phases, and
// checks every output transfer against an in-bench power iteration model.
// ----------------------------------------------------------------------------
module power_iteration_eigen_test;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int DIM = 10;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [1:0]  action;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [31:0] value;
  } load_t;

  typedef struct {
    logic        is_ev;
    logic [3:0]  index;
    logic [31:0] value;
    logic [1:0]  status;
    logic        last;
  } eigen_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // row[3:0], col[7:4], value[39:8]
  logic [1:0]  in_tuser = '0;   // action[1:0]
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;       // index[3:0], result_value[35:4], status[37:36]
  logic        out_tuser;       // is_eigenvalue
  logic        out_tlast;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  power_iteration_eigen dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // model state
  longint mat [DIM][DIM];
  longint guess [DIM];
  logic [3:0]  cur_order = piev_pkg::ORDER_RST;
  logic [15:0] cur_tol = piev_pkg::TOL_RST;
  logic [15:0] cur_limit = piev_pkg::LIMIT_RST;

  load_t  load_q[$];
  eigen_t eigen_q[$];
  load_t  cur;
  bit     busy = 0;
  bit     no_idle = 0;
  bit     hold_off = 0;
  int     gap = 0;
  int     stall = 0;
  int     errors = 0;
  int     received = 0;
  int     stim_count = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qdiv(longint x, longint m);
    return sat32((x * 65536) / m);
  endfunction

  task automatic mat_vec(input int n, input longint src[DIM], output longint dst[DIM]);
    longint sum;
    dst = src;
    for (int i = 0; i < n; i++) begin
      sum = 0;
      for (int k = 0; k < n; k++) sum += (mat[i][k] * src[k]) >>> 16;
      dst[i] = sat32(sum);
    end
  endtask

  function automatic longint vmax(int n, longint v[DIM]);
    longint m;
    m = v[0];
    for (int i = 1; i < n; i++) if (v[i] > m) m = v[i];
    return m;
  endfunction

  task automatic push_eigen(logic ev, int idx, longint v, logic [1:0] st, logic lst);
    eigen_t e;
    e.is_ev = ev;
    e.index = idx[3:0];
    e.value = v[31:0];
    e.status = st;
    e.last = lst;
    eigen_q.insert(eigen_q.size(), e);
  endtask

  task automatic solve_power();
    int n;
    int rounds;
    int lim;
    longint x[DIM];
    longint m0;
    longint m1;
    longint diff;
    logic [1:0] st;
    n = (cur_order == 0) ? 1 : (cur_order > DIM) ? DIM : cur_order;
    lim = (cur_limit == 0) ? 1 : cur_limit;
    rounds = 0;
    mat_vec(n, guess, x);
    forever begin
      m0 = vmax(n, x);
      if (m0 == 0) begin
        push_eigen(1, 0, 0, piev_pkg::ST_ZERO_DIV, 1);
        return;
      end
      for (int i = 0; i < n; i++) x[i] = qdiv(x[i], m0);
      mat_vec(n, x, x);
      m1 = vmax(n, x);
      rounds++;
      diff = (m0 > m1) ? m0 - m1 : m1 - m0;
      if (diff <= cur_tol) begin
        st = piev_pkg::ST_CONVERGED;
        break;
      end
      if (rounds >= lim) begin
        st = piev_pkg::ST_LIMIT;
        break;
      end
    end
    if (m1 == 0) begin
      push_eigen(1, 0, 0, piev_pkg::ST_ZERO_DIV, 1);
      return;
    end
    push_eigen(1, 0, m1, st, 0);
    for (int i = 0; i < n; i++) push_eigen(0, i, qdiv(x[i], m1), st, i == n - 1);
  endtask

  task automatic apply_load(load_t it);
    case (it.action)
      piev_pkg::ACT_LOAD_MATRIX: if (it.row < DIM && it.col < DIM)
        mat[it.row][it.col] = longint'($signed(it.value));
      piev_pkg::ACT_LOAD_GUESS: if (it.row < DIM)
        guess[it.row] = longint'($signed(it.value));
      piev_pkg::ACT_START: solve_power();
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        apply_load(cur);
        busy = 0;
        gap = pick_gap();
      end
      if (!busy) begin
        if (gap > 0) gap--;
        else if (load_q.size() > 0) begin
          cur = load_q.pop_front();
          busy = 1;
        end
      end
      in_tvalid <= busy;
      in_tdata <= {cur.value, cur.col, cur.row};
      in_tuser <= cur.action;
    end
  end

  // long receiver hold-off once the first results are flowing
  always @(posedge clk) begin : hold_proc
    int cnt;
    if (rst_n && !hold_off && received == 3) begin
      hold_off <= 1;
      cnt = 0;
    end else if (hold_off) begin
      cnt++;
      if (cnt == 400) begin
        hold_off <= 0;
        received = 4;
      end
    end
  end

  // output monitor
  always @(posedge clk) begin : mon
    eigen_t e;
    bit rdy;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (received < 3) received++;
        if (eigen_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transfer tdata=%h tuser=%b", $time, out_tdata, out_tuser);
        end else begin
          e = eigen_q.pop_front();
          if (out_tuser !== e.is_ev || out_tdata[3:0] !== e.index ||
              out_tdata[35:4] !== e.value || out_tdata[37:36] !== e.status ||
              out_tlast !== e.last) begin
            errors++;
            $display("%0t: expected ev=%b idx=%0d val=%h st=%0d last=%b", $time,
                     e.is_ev, e.index, e.value, e.status, e.last);
            $display("%0t: actual   ev=%b idx=%0d val=%h st=%0d last=%b", $time,
                     out_tuser, out_tdata[3:0], out_tdata[35:4], out_tdata[37:36],
                     out_tlast);
          end
        end
      end
      if (stall > 0) begin
        stall--;
        rdy = 0;
      end else begin
        stall = pick_gap();
        rdy = (stall == 0);
      end
      out_tready <= rdy && !hold_off;
    end
  end

  always @(posedge clk) begin : watchdog
    int cycles;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send(logic [1:0] a, int r, int c, logic [31:0] v);
    load_t it;
    it.action = a;
    it.row = r[3:0];
    it.col = c[3:0];
    it.value = v;
    load_q.insert(load_q.size(), it);
    if (a != ACT_UNUSED && r < DIM && (a != piev_pkg::ACT_LOAD_MATRIX || c < DIM))
      stim_count++;
  endtask

  task automatic wait_idle();
    while (load_q.size() != 0 || busy || in_tvalid || eigen_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    wait_idle();
    @(posedge clk);
    psel <= 1;
    pwrite <= 1;
    penable <= 0;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    case (idx)
      piev_pkg::REG_ORDER: cur_order = v[3:0];
      piev_pkg::REG_TOLERANCE: cur_tol = v[15:0];
      default: cur_limit = v[15:0];
    endcase
  endtask

  function automatic logic [31:0] rand_q16();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return 32'h0;
      4: return 32'h00010000;
      default: return $urandom_range(0, 32'h00080000) - 32'h00040000;
    endcase
  endfunction

  task automatic config_set(int o, int t, int l);
    reg_write(piev_pkg::REG_ORDER, o);
    reg_write(piev_pkg::REG_TOLERANCE, t);
    reg_write(piev_pkg::REG_ITER_LIMIT, l);
  endtask

  initial begin
    int n;
    int k;
    for (int i = 0; i < DIM; i++) begin
      guess[i] = 0;
      for (int j = 0; j < DIM; j++) mat[i][j] = 0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1;

    // full diagonal setup at reset settings, plus ignored items
    no_idle = 1;
    for (int i = 0; i < DIM; i++) begin
      for (int j = 0; j < DIM; j++)
        send(piev_pkg::ACT_LOAD_MATRIX, i, j, (i == j) ? 32'h00020000 : 0);
      send(piev_pkg::ACT_LOAD_GUESS, i, 0, (i + 1) << 16);
    end
    send(ACT_UNUSED, 1, 1, 32'hffffffff);
    send(piev_pkg::ACT_LOAD_MATRIX, 12, 3, 32'h12345678);
    send(piev_pkg::ACT_LOAD_MATRIX, 3, 15, 32'h12345678);
    send(piev_pkg::ACT_LOAD_GUESS, 11, 0, 32'h87654321);
    send(piev_pkg::ACT_START, 0, 0, 0);
    send(piev_pkg::ACT_START, 0, 0, 0);
    no_idle = 0;

    config_set(15, 0, 65535);
    send(piev_pkg::ACT_START, 0, 0, 0);
    config_set(0, 65535, 0);
    send(piev_pkg::ACT_START, 0, 0, 0);

    // zero guess, then nilpotent matrix giving a zero eigenvalue
    config_set(2, 33, 1);
    send(piev_pkg::ACT_LOAD_GUESS, 0, 0, 0);
    send(piev_pkg::ACT_LOAD_GUESS, 1, 0, 0);
    send(piev_pkg::ACT_START, 0, 0, 0);
    send(piev_pkg::ACT_LOAD_MATRIX, 0, 0, 0);
    send(piev_pkg::ACT_LOAD_MATRIX, 0, 1, 32'h00010000);
    send(piev_pkg::ACT_LOAD_MATRIX, 1, 0, 0);
    send(piev_pkg::ACT_LOAD_MATRIX, 1, 1, 0);
    send(piev_pkg::ACT_LOAD_GUESS, 1, 0, 32'h00010000);
    send(piev_pkg::ACT_START, 0, 0, 0);

    // negative and extreme entries
    config_set(2, 100, 5);
    send(piev_pkg::ACT_LOAD_MATRIX, 0, 0, 32'h80000000);
    send(piev_pkg::ACT_LOAD_MATRIX, 1, 1, 32'h7fffffff);
    send(piev_pkg::ACT_LOAD_GUESS, 0, 0, 32'hffff0000);
    send(piev_pkg::ACT_START, 0, 0, 0);

    while (stim_count < 170) begin
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, DIM) : $urandom_range(1, 4);
      no_idle = ($urandom_range(0, 4) == 0);
      config_set(n, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                    : $urandom_range(0, 200),
                 (n > 4) ? $urandom_range(1, 3) : $urandom_range(1, 10));
      repeat ($urandom_range(1, 3)) begin
        k = (n * n < 12) ? n * n : 12;
        for (int i = 0; i < k; i++) begin
          if ($urandom_range(0, 9) == 0)
            send($urandom_range(0, 9) == 0 ? ACT_UNUSED : piev_pkg::ACT_LOAD_MATRIX,
                 $urandom_range(0, 15), $urandom_range(10, 15), $urandom());
          send(piev_pkg::ACT_LOAD_MATRIX,
               (n * n <= 12) ? i / n : $urandom_range(0, n - 1),
               (n * n <= 12) ? i % n : $urandom_range(0, n - 1), rand_q16());
        end
        for (int i = 0; i < n; i++)
          send(piev_pkg::ACT_LOAD_GUESS, i, $urandom_range(0, 15), rand_q16());
        send(piev_pkg::ACT_START, $urandom_range(0, 15), $urandom_range(0, 15), $urandom());
      end
    end

    wait_idle();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
